// ----- rtl/mcpt_pkg.sv -----
// mcpt_pkg: shared types, codes and the per-channel update function
// for the multi-channel power-on timer. No dependencies.

package mcpt_pkg;

   // width of the per-channel masks on the result beat
   localparam int MASK_W = 4;

   // command codes on the request beat
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_FLAGS = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // channel power codes
   typedef enum logic [1:0] {
      PWR_OFF     = 2'd0,
      PWR_ON      = 2'd1,
      PWR_UNKNOWN = 2'd2
   } power_type;

   // configuration register indexes
   localparam logic REG_HEARTBEAT_LIMIT = 1'b0;
   localparam logic REG_REPLY_LIMIT     = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPORT
   } state_type;

   // one channel record, held by one cell of the ring
   typedef struct packed {
      power_type         power;
      logic [15:0]       length;
      logic [15:0]       elapsed;
   } chan_type;

   // result of advancing one channel by one tick
   typedef struct packed {
      chan_type next;
      logic     fire;
   } upd_type;

   // load code 3 maps to unknown
   function automatic power_type decode_power(input logic [1:0] code);
      power_type p;
      unique case (code)
         2'd0:    p = PWR_OFF;
         2'd1:    p = PWR_ON;
         default: p = PWR_UNKNOWN;
      endcase
      return p;
   endfunction

   // advance one channel record by one tick
   function automatic upd_type tick_chan(input chan_type c);
      upd_type u;
      u.next = c;
      u.fire = 1'b0;
      case (c.power)
         PWR_ON: begin
            if (c.length == 16'd0) begin
               u.next.power = PWR_UNKNOWN;
            end else if (c.elapsed >= c.length) begin
               u.next.power   = PWR_OFF;
               u.next.length  = 16'd0;
               u.next.elapsed = 16'd0;
               u.fire         = 1'b1;
            end else begin
               u.next.elapsed = c.elapsed + 16'd1;
            end
         end
         PWR_OFF: begin
            if (c.length != 16'd0) begin
               u.next.power = PWR_UNKNOWN;
            end
         end
         default: begin
            u.next = c;
         end
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/mcpt_if.sv -----
// mcpt_if: valid/ready channel interfaces for request and result beats.
// Depends on nothing outside this file.

interface mcpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [1:0]  device_index;
   logic [1:0]  power_state;
   logic [15:0] duration_ticks;
   logic [15:0] elapsed_ticks;
   logic        wait_reply_in;
   logic        logged_in_in;
   logic        heartbeat_ready_in;
   logic        clear_reply_count;
   logic [3:0]  closed_clear_mask;

   modport source (
      output valid, command, device_index, power_state, duration_ticks,
             elapsed_ticks, wait_reply_in, logged_in_in, heartbeat_ready_in,
             clear_reply_count, closed_clear_mask,
      input  ready
   );
   modport sink (
      input  valid, command, device_index, power_state, duration_ticks,
             elapsed_ticks, wait_reply_in, logged_in_in, heartbeat_ready_in,
             clear_reply_count, closed_clear_mask,
      output ready
   );
endinterface

interface mcpt_rsp_if;
   logic        valid;
   logic        ready;
   logic        heartbeat_ready;
   logic [15:0] reply_count;
   logic [3:0]  closed_ports;
   logic [3:0]  switched_off_now;
   logic [3:0]  unknown_channels;
   logic        waiting_reply;

   modport source (
      output valid, heartbeat_ready, reply_count, closed_ports,
             switched_off_now, unknown_channels, waiting_reply,
      input  ready
   );
   modport sink (
      input  valid, heartbeat_ready, reply_count, closed_ports,
             switched_off_now, unknown_channels, waiting_reply,
      output ready
   );
endinterface

// ----- rtl/mcpt_cell.sv -----
// mcpt_cell: one ring cell holding a channel record; takes its neighbor's
// record on a shift, or a direct load. Depends on mcpt_pkg.

module mcpt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  mcpt_pkg::chan_type shift_in,
   input  logic              load_en,
   input  mcpt_pkg::chan_type load_data,
   output mcpt_pkg::chan_type chan_out
);

   mcpt_pkg::chan_type chan_ff;
   mcpt_pkg::chan_type chan_in;

   // shift has priority; loads only happen while the ring rests
   always_comb begin
      chan_in = chan_ff;
      if (shift_en) begin
         chan_in = shift_in;
      end else if (load_en) begin
         chan_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff.power   <= mcpt_pkg::PWR_OFF;
         chan_ff.length  <= 16'd0;
         chan_ff.elapsed <= 16'd0;
      end else begin
         chan_ff <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

// ----- rtl/multi_channel_power_on_timer.sv -----
// multi_channel_power_on_timer: top level, sequencer plus a ring of
// channel cells. Depends on mcpt_pkg, mcpt_if and mcpt_cell.
//
// Usage
//   req_bus carries one command per beat: tick, load a channel, or set
//   the host flags. rsp_bus returns exactly one status beat per request,
//   showing the state after that command. csr_* writes the heartbeat and
//   reply limits; write them only while the block is idle.
// Sequence
//   load / set-flags / unused command: the command takes effect at
//   acceptance, then ST_REPORT registers the status beat.
//   tick: the channel records rotate once through the ring in ST_WALK,
//   one record through the update logic per cycle, then ST_REPORT
//   registers the status beat; the next request is taken only in ST_IDLE.
//   One request is in work at a time.
// Reset
//   synchronous, active high: all channels off with zero counts, flags and
//   counters cleared, both limits back to 60, no result pending.
// Stall
//   a result held by a stalled receiver stays in the output register and
//   holds off the next request until the receiver takes it.

module multi_channel_power_on_timer #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic           clock,
   input  logic           reset,
   mcpt_req_if.sink       req_bus,
   mcpt_rsp_if.source     rsp_bus,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [15:0]    csr_wdata
);

   localparam int STEP_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_CHANNELS - 1);

   // control state
   mcpt_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff;
   logic                tick_ff;
   logic                rsp_valid_ff;

   // host-side state
   logic [15:0] hb_limit_ff, reply_limit_ff;
   logic [15:0] hb_count_ff, reply_ff, reply_in;
   logic        hb_flag_ff, await_ff, logged_ff;
   logic [3:0]  closed_ff, fired_ff;

   // result payload registers
   logic        rsp_hb_ff, rsp_wait_ff;
   logic [15:0] rsp_reply_ff;
   logic [3:0]  rsp_closed_ff, rsp_fired_ff, rsp_unk_ff;

   logic               accept, shift_en, report;
   mcpt_pkg::chan_type ring [NUM_CHANNELS];
   mcpt_pkg::chan_type load_data;
   mcpt_pkg::upd_type  head_upd;
   logic [3:0]         unk_mask, fire_bit;
   logic               load_cmd;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_bus.ready  = 1'b0;
      shift_en       = 1'b0;
      report         = 1'b0;
      unique case (state_ff)
         mcpt_pkg::ST_IDLE: begin
            req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
            if (req_bus.valid && req_bus.ready) begin
               state_in = (mcpt_pkg::cmd_type'(req_bus.command) == mcpt_pkg::CMD_TICK)
                          ? mcpt_pkg::ST_WALK : mcpt_pkg::ST_REPORT;
            end
         end
         mcpt_pkg::ST_WALK: begin
            shift_en = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = mcpt_pkg::ST_REPORT;
            end
         end
         mcpt_pkg::ST_REPORT: begin
            report   = 1'b1;
            state_in = mcpt_pkg::ST_IDLE;
         end
         default: begin
            state_in = mcpt_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept   = req_bus.valid && req_bus.ready;
   assign load_cmd = accept &&
                     (mcpt_pkg::cmd_type'(req_bus.command) == mcpt_pkg::CMD_LOAD);

   // walk step counter names the channel at the ring head
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         tick_ff <= 1'b0;
      end else begin
         if (accept) begin
            step_ff <= '0;
            tick_ff <= (mcpt_pkg::cmd_type'(req_bus.command) == mcpt_pkg::CMD_TICK);
         end else if (shift_en) begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // ring of channel cells; the head record passes the update on its way round
   assign head_upd = mcpt_pkg::tick_chan(ring[0]);

   always_comb begin
      load_data.power   = mcpt_pkg::decode_power(req_bus.power_state);
      load_data.length  = req_bus.duration_ticks;
      load_data.elapsed = req_bus.elapsed_ticks;
   end

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      mcpt_pkg::chan_type shift_src;
      logic               load_here;

      if (i == NUM_CHANNELS - 1) begin : g_tail
         assign shift_src = head_upd.next;
      end else begin : g_mid
         assign shift_src = ring[i+1];
      end

      if (i < mcpt_pkg::MASK_W) begin : g_addr
         assign load_here = load_cmd && (req_bus.device_index == 2'(i));
      end else begin : g_noaddr
         assign load_here = 1'b0;
      end

      mcpt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .shift_in  (shift_src),
         .load_en   (load_here),
         .load_data (load_data),
         .chan_out  (ring[i])
      );
   end

   // unknown mask from the resting ring
   for (genvar b = 0; b < mcpt_pkg::MASK_W; b++) begin : g_unk
      if (b < NUM_CHANNELS) begin : g_have
         assign unk_mask[b] = (ring[b].power == mcpt_pkg::PWR_UNKNOWN);
      end else begin : g_none
         assign unk_mask[b] = 1'b0;
      end
   end

   // mask bit of the channel now at the head, if it expires
   always_comb begin
      fire_bit = '0;
      for (int b = 0; b < mcpt_pkg::MASK_W; b++) begin
         if (b < NUM_CHANNELS && step_ff == STEP_W'(b)) begin
            fire_bit[b] = shift_en && head_upd.fire;
         end
      end
   end

   // reply counter advances at most once per tick, after all channels
   always_comb begin
      reply_in = reply_ff;
      if (tick_ff && (await_ff || !logged_ff) && (reply_ff < reply_limit_ff)) begin
         reply_in = reply_ff + 16'd1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_limit_ff    <= 16'd60;
         reply_limit_ff <= 16'd60;
      end else if (csr_we) begin
         unique case (csr_index)
            mcpt_pkg::REG_HEARTBEAT_LIMIT: hb_limit_ff    <= csr_wdata;
            mcpt_pkg::REG_REPLY_LIMIT:     reply_limit_ff <= csr_wdata;
            default:                       hb_limit_ff    <= hb_limit_ff;
         endcase
      end
   end

   // heartbeat, host flags, closed and fired masks and reply counter
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_count_ff <= 16'd0;
         hb_flag_ff  <= 1'b0;
         await_ff    <= 1'b0;
         logged_ff   <= 1'b0;
         closed_ff   <= 4'd0;
         fired_ff    <= 4'd0;
         reply_ff    <= 16'd0;
      end else begin
         if (accept) begin
            fired_ff <= 4'd0;
            case (mcpt_pkg::cmd_type'(req_bus.command))
               mcpt_pkg::CMD_TICK: begin
                  if (!hb_flag_ff) begin
                     if (hb_count_ff >= hb_limit_ff) begin
                        hb_flag_ff  <= 1'b1;
                        hb_count_ff <= 16'd0;
                     end else begin
                        hb_count_ff <= hb_count_ff + 16'd1;
                     end
                  end
               end
               mcpt_pkg::CMD_FLAGS: begin
                  await_ff   <= req_bus.wait_reply_in;
                  logged_ff  <= req_bus.logged_in_in;
                  hb_flag_ff <= req_bus.heartbeat_ready_in;
                  closed_ff  <= closed_ff & ~req_bus.closed_clear_mask;
                  if (req_bus.clear_reply_count) begin
                     reply_ff <= 16'd0;
                  end
               end
               default: begin
               end
            endcase
         end else if (shift_en) begin
            fired_ff  <= fired_ff | fire_bit;
            closed_ff <= closed_ff | fire_bit;
            if (head_upd.fire) begin
               await_ff <= 1'b0;
            end
         end else if (report) begin
            reply_ff <= reply_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (report) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (report) begin
         rsp_hb_ff     <= hb_flag_ff;
         rsp_reply_ff  <= reply_in;
         rsp_closed_ff <= closed_ff;
         rsp_fired_ff  <= fired_ff;
         rsp_unk_ff    <= unk_mask;
         rsp_wait_ff   <= await_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.heartbeat_ready  = rsp_hb_ff;
   assign rsp_bus.reply_count      = rsp_reply_ff;
   assign rsp_bus.closed_ports     = rsp_closed_ff;
   assign rsp_bus.switched_off_now = rsp_fired_ff;
   assign rsp_bus.unknown_channels = rsp_unk_ff;
   assign rsp_bus.waiting_reply    = rsp_wait_ff;

endmodule
